FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the integer literal parser (included by its top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ILP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ILP_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: hw/rtl/ilp_pkg.sv
// Package with types, codes and constants of the integer literal parser.
package ilp_pkg;

   localparam int VALUE_WIDTH_DEF = 64;
   localparam int VALUE_OUT_W     = 64;

   // Parser phase codes
   localparam logic [1:0] PH_START  = 2'd0;
   localparam logic [1:0] PH_ZERO   = 2'd1;
   localparam logic [1:0] PH_DIGITS = 2'd2;
   localparam logic [1:0] PH_SUFFIX = 2'd3;

   // Radix codes
   localparam logic [4:0] RADIX_BIN = 5'd2;
   localparam logic [4:0] RADIX_OCT = 5'd8;
   localparam logic [4:0] RADIX_DEC = 5'd10;
   localparam logic [4:0] RADIX_HEX = 5'd16;

   // Characters
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_NINE   = 8'h39;
   localparam logic [7:0] CHR_UP_A   = 8'h41;
   localparam logic [7:0] CHR_UP_F   = 8'h46;
   localparam logic [7:0] CHR_LO_A   = 8'h61;
   localparam logic [7:0] CHR_LO_F   = 8'h66;
   localparam logic [7:0] CHR_UP_X   = 8'h58;
   localparam logic [7:0] CHR_LO_X   = 8'h78;
   localparam logic [7:0] CHR_UP_B   = 8'h42;
   localparam logic [7:0] CHR_LO_B   = 8'h62;
   localparam logic [7:0] CHR_UP_U   = 8'h55;
   localparam logic [7:0] CHR_LO_U   = 8'h75;
   localparam logic [7:0] CHR_UP_L   = 8'h4C;
   localparam logic [7:0] CHR_LO_L   = 8'h6C;
   localparam logic [7:0] CHR_UP_H   = 8'h48;
   localparam logic [7:0] CHR_LO_H   = 8'h68;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_OUT_W-1:0] value;
      logic                   status;
      logic                   done_res;
   } rsp_payload_type;

   // Parser control state (accumulator is kept apart, its width is a parameter)
   typedef struct packed {
      logic [1:0] phase;
      logic [4:0] radix;
      logic       bad;
   } ctl_type;

   localparam ctl_type CTL_RESET = '{phase: PH_START, radix: RADIX_DEC, bad: 1'b0};

endpackage

FILE: hw/rtl/ilp_step.sv
// Per-character step of the parser: classify, update phase/radix and accumulate.
module ilp_step import ilp_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  req_payload_type        req,
   input  ctl_type                cur_ctl,
   input  logic [VALUE_WIDTH-1:0] cur_accum,
   output ctl_type                next_ctl,
   output logic [VALUE_WIDTH-1:0] next_accum,
   output rsp_payload_type        rsp
);

   logic                   is_digit;
   logic [3:0]             digit;
   logic                   is_suffix;
   logic                   is_x;
   logic                   is_b;
   logic                   take;
   logic [4:0]             eff_radix;
   logic [VALUE_WIDTH-1:0] scaled;
   ctl_type                sel_ctl;
   ctl_type                step_ctl;
   logic [VALUE_WIDTH-1:0] step_accum;

   always_comb begin
      is_digit = 1'b1;
      digit    = '0;
      if (req.ch inside {[CHR_ZERO:CHR_NINE]}) begin
         digit = 4'(req.ch - CHR_ZERO);
      end else if (req.ch inside {[CHR_UP_A:CHR_UP_F]}) begin
         digit = 4'(req.ch - CHR_UP_A + 8'd10);
      end else if (req.ch inside {[CHR_LO_A:CHR_LO_F]}) begin
         digit = 4'(req.ch - CHR_LO_A + 8'd10);
      end else begin
         is_digit = 1'b0;
      end
      is_suffix = req.ch inside {CHR_UP_U, CHR_LO_U, CHR_UP_L, CHR_LO_L, CHR_UP_H, CHR_LO_H};
      is_x      = req.ch inside {CHR_UP_X, CHR_LO_X};
      is_b      = req.ch inside {CHR_UP_B, CHR_LO_B};
   end

   always_comb begin
      sel_ctl   = cur_ctl;
      take      = 1'b0;
      eff_radix = cur_ctl.radix;
      case (cur_ctl.phase)
         PH_START: begin
            if (req.ch == CHR_ZERO) begin
               sel_ctl.radix = RADIX_OCT;
               sel_ctl.phase = PH_ZERO;
            end else begin
               sel_ctl.radix = RADIX_DEC;
               eff_radix     = RADIX_DEC;
               take          = 1'b1;
            end
         end
         PH_ZERO: begin
            if (is_x) begin
               sel_ctl.radix = RADIX_HEX;
               sel_ctl.phase = PH_DIGITS;
            end else if (is_b) begin
               sel_ctl.radix = RADIX_BIN;
               sel_ctl.phase = PH_DIGITS;
            end else begin
               sel_ctl.radix = RADIX_OCT;
               eff_radix     = RADIX_OCT;
               take          = 1'b1;
            end
         end
         PH_DIGITS: take = 1'b1;
         default: ;
      endcase
   end

   // accum * radix for the four legal bases, as shifts and one add
   always_comb begin
      case (eff_radix)
         RADIX_BIN: scaled = cur_accum << 1;
         RADIX_OCT: scaled = cur_accum << 3;
         RADIX_HEX: scaled = cur_accum << 4;
         default:   scaled = (cur_accum << 3) + (cur_accum << 1);
      endcase
   end

   always_comb begin
      step_ctl   = sel_ctl;
      step_accum = cur_accum;
      if (take) begin
         step_ctl.phase = PH_DIGITS;
         if (!is_digit) begin
            if (is_suffix) begin
               step_ctl.phase = PH_SUFFIX;
            end else begin
               step_ctl.bad = 1'b1;
            end
         end else if ({1'b0, digit} >= eff_radix) begin
            step_ctl.bad = 1'b1;
         end else begin
            step_accum = scaled + VALUE_WIDTH'(digit);
         end
      end
   end

   always_comb begin
      rsp.value    = VALUE_OUT_W'(step_accum);
      rsp.status   = step_ctl.bad;
      rsp.done_res = req.last;
      // literal ends: back to reset state
      next_ctl   = req.last ? CTL_RESET : step_ctl;
      next_accum = req.last ? '0 : step_accum;
   end

endmodule

FILE: hw/rtl/integer_literal_parser.sv
// Top level of the integer literal parser: input register, step logic, result register.
//
// Usage:
//   req_ channel carries one character of a literal per transfer, with last
//   set on the final character. The base comes from the prefix (0x hex, 0b
//   binary, leading 0 octal, else decimal); a U, L or H suffix ends digits.
//   rsp_ channel returns exactly one result per character: the running value
//   (wrapping modulo 2^VALUE_WIDTH, zero above), a sticky error flag and a
//   copy of last. After the last character the parser is back at reset.
//   Path: a character goes into the input register, then its result into
//   the result register, where rsp_stall can hold it.
//   Throughput: one character per cycle while no result is stalled; the step
//   is one classifier and one shift-and-add between the input register and the result register.
//   Reset: synchronous, active high; clears both valids and the parser state.
//   Stall: while rsp_stall holds a result, one more character can wait in
//   the input register; after that req_stall rises until the result moves.
`include "assert_macros.svh"

module integer_literal_parser import ilp_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   // input register
   req_payload_type        req_ff;
   logic                   req_vld_ff, req_vld_in;
   // result register
   rsp_payload_type        rsp_ff;
   logic                   rsp_vld_ff, rsp_vld_in;
   // parser state
   ctl_type                ctl_ff, ctl_in;
   logic [VALUE_WIDTH-1:0] accum_ff, accum_in;
   rsp_payload_type        step_rsp;

   logic req_take;
   logic advance;

   // item moves from input register to result register
   assign advance   = req_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = req_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign req_vld_in = req_take || (req_vld_ff && !advance);
   assign rsp_vld_in = advance || (rsp_vld_ff && rsp_stall);

   ilp_step #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_step (
      .req        (req_ff),
      .cur_ctl    (ctl_ff),
      .cur_accum  (accum_ff),
      .next_ctl   (ctl_in),
      .next_accum (accum_in),
      .rsp        (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         ctl_ff     <= CTL_RESET;
         accum_ff   <= '0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (advance) begin
            ctl_ff   <= ctl_in;
            accum_ff <= accum_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

   // state is back at reset after the last character of a literal
   `ILP_ASSERT(a_reset_after_last, clock, reset,
      (advance && req_ff.last) |=> (ctl_ff == CTL_RESET && accum_ff == '0), "state not cleared")
   // error flag stays set within a literal
   `ILP_ASSERT(a_bad_sticky, clock, reset,
      (advance && !req_ff.last && ctl_ff.bad) |=> ctl_ff.bad, "error flag dropped mid-literal")
   // value never carries bits above the accumulator width
   `ILP_ASSERT(a_value_width, clock, reset,
      rsp_vld_ff |-> ((rsp_ff.value >> VALUE_WIDTH) == '0), "value exceeds width")
   // input side only waits when a character is held
   `ILP_NEVER(a_stall_empty, clock, reset,
      req_stall && !req_vld_ff, "stall with empty input register")

endmodule
